// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define GTCR_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GTCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/gtcr_pkg.sv -----
package gtcr_pkg;

	localparam int DEF_GLYPH_COUNT      = 256;
	localparam int DEF_MAX_GLYPH_HEIGHT = 32;
	localparam int DEF_MAX_GLYPH_WIDTH  = 16;

	localparam int PIX_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 48;

	localparam logic [1:0] OP_PRINT = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;

	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_W  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_H  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLY_W  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLY_H  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BG     = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic [31:0] foreground;
		logic [7:0]  glyph_index;
		logic [4:0]  glyph_row;
		logic [15:0] row_bits;
		logic [8:0]  cell_col;
		logic [7:0]  cell_row;
	} in_item_t;

	typedef struct packed {
		logic [47:0] write_address;
		logic [15:0] pixel_on_bits;
		logic [15:0] column_enable;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [47:0] buffer_base_address;
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [12:0] row_stride_pixels;
		logic [4:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [31:0] background_color;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_PRINT,
		KIND_NEWLINE
	} kind_t;

	typedef struct packed {
		logic accept;
		logic setup_mul;
		logic setup_addr;
		logic issue;
		logic adv_x;
		logic new_line;
		logic top_chk;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  emit_ok;
		logic  can_issue;
		logic  last_row;
		logic  line_wrap;
	} dp_sts_t;

endpackage

// ----- hw/rtl/gtcr_cfg_regs.sv -----
module gtcr_cfg_regs
	import gtcr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_base_address <= '0;
			cfg_q.screen_width        <= 12'd640;
			cfg_q.screen_height       <= 12'd480;
			cfg_q.row_stride_pixels   <= 13'd640;
			cfg_q.glyph_width         <= 5'd8;
			cfg_q.glyph_height        <= 6'd16;
			cfg_q.background_color    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE:   cfg_q.buffer_base_address <= cfg_data[47:0];
				REG_SCR_W:  cfg_q.screen_width        <= cfg_data[11:0];
				REG_SCR_H:  cfg_q.screen_height       <= cfg_data[11:0];
				REG_STRIDE: cfg_q.row_stride_pixels   <= cfg_data[12:0];
				REG_GLY_W:  cfg_q.glyph_width         <= cfg_data[4:0];
				REG_GLY_H:  cfg_q.glyph_height        <= cfg_data[5:0];
				REG_BG:     cfg_q.background_color    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/gtcr_datapath.sv -----
module gtcr_datapath
	import gtcr_pkg::*;
#(
	parameter int GLYPH_COUNT      = DEF_GLYPH_COUNT,
	parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
	parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  in_item,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMPW  = $clog2(GLYPH_COUNT) + 1;
	localparam int MW    = (MAX_GLYPH_WIDTH < PIX_W) ? MAX_GLYPH_WIDTH : PIX_W;

	localparam logic [4:0]      MW_C  = 5'(MW);
	localparam logic [5:0]      MH_C  = 6'(MAX_GLYPH_HEIGHT);
	localparam logic [CMPW-1:0] GC_C  = CMPW'(GLYPH_COUNT);
	localparam logic [AW-1:0]   MH_A  = AW'(MAX_GLYPH_HEIGHT);

	logic [15:0] mem [DEPTH];

	logic [4:0]  w_cell;
	logic [5:0]  h_cell;
	logic [15:0] hmask;
	logic        load_ok;
	logic        s1_move;
	logic        can_issue;
	logic        top_wrap;
	logic [AW-1:0] wr_idx;

	logic [12:0] x_q, y_q;
	logic [7:0]  code_q;
	logic [31:0] fg_q;
	logic [25:0] prod_q;
	logic [47:0] addr_q;
	logic [15:0] hmask_q;
	logic [AW-1:0] rd_ptr_q;
	logic [13:0] yrow_q;
	logic [5:0]  r_q;
	logic        emit_ok_q;

	logic        s1_valid_q;
	logic [47:0] addr_s1;
	logic [15:0] en_s1;
	logic [15:0] rdata_s1;
	logic [31:0] fg_s1;
	logic [31:0] bg_s1;
	logic        last_s1;

	logic        out_valid_q;
	out_item_t   out_q;

	always_comb begin
		w_cell = (cfg.glyph_width > MW_C) ? MW_C : cfg.glyph_width;
		h_cell = (cfg.glyph_height > MH_C) ? MH_C : cfg.glyph_height;
		for (int c = 0; c < PIX_W; c++) begin
			hmask[PIX_W-1-c] = (5'(c) < w_cell) &&
				((14'(x_q) + 14'(c)) < 14'(cfg.screen_width));
		end
		load_ok = (CMPW'(in_item.glyph_index) < GC_C) && ({1'b0, in_item.glyph_row} < MH_C);
		wr_idx  = AW'(in_item.glyph_index) * MH_A + AW'(in_item.glyph_row);
		s1_move   = s1_valid_q && (!out_valid_q || !out_stall);
		can_issue = !s1_valid_q || s1_move;
		top_wrap  = (14'(y_q) + 14'(h_cell)) > 14'(cfg.screen_height);
	end

	always_comb begin
		if (in_item.op == OP_PRINT && in_item.char_code == CHAR_LF) begin
			sts.kind = KIND_NEWLINE;
		end else if (in_item.op == OP_PRINT && in_item.char_code != CHAR_NUL &&
				in_item.char_code != CHAR_CR) begin
			sts.kind = KIND_PRINT;
		end else begin
			sts.kind = KIND_OTHER;
		end
		sts.emit_ok   = emit_ok_q;
		sts.can_issue = can_issue;
		sts.last_row  = (r_q + 6'd1) == h_cell;
		sts.line_wrap = (14'(x_q) + 14'(w_cell)) > 14'(cfg.screen_width);
	end

	// glyph store
	always_ff @(posedge clk) begin
		if (cmd.accept && in_item.op == OP_LOAD && load_ok) begin
			mem[wr_idx] <= in_item.row_bits;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	// cursor and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && in_item.op == OP_SET) begin
				x_q <= 13'(14'(in_item.cell_col) * 14'(w_cell));
				y_q <= 13'(14'(in_item.cell_row) * 14'(h_cell));
			end else if (cmd.accept && in_item.op == OP_PRINT &&
					in_item.char_code == CHAR_CR) begin
				x_q <= '0;
			end else if (cmd.adv_x) begin
				x_q <= x_q + 13'(w_cell);
			end else if (cmd.new_line) begin
				x_q <= '0;
				y_q <= y_q + 13'(h_cell);
			end else if (cmd.top_chk && top_wrap) begin
				y_q <= '0;
			end

			if (cmd.issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// setup and row payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= in_item.char_code;
			fg_q   <= in_item.foreground;
		end
		if (cmd.setup_mul) begin
			prod_q    <= 26'(y_q) * 26'(cfg.row_stride_pixels);
			hmask_q   <= hmask;
			rd_ptr_q  <= AW'(code_q) * MH_A;
			yrow_q    <= 14'(y_q);
			r_q       <= '0;
			emit_ok_q <= (h_cell != 6'd0) && (CMPW'(code_q) < GC_C);
		end
		if (cmd.setup_addr) begin
			addr_q <= cfg.buffer_base_address + 48'({27'(prod_q) + 27'(x_q), 2'b00});
		end
		if (cmd.issue) begin
			addr_s1  <= addr_q;
			en_s1    <= (yrow_q < 14'(cfg.screen_height)) ? hmask_q : '0;
			last_s1  <= sts.last_row;
			fg_s1    <= fg_q;
			bg_s1    <= cfg.background_color;
			addr_q   <= addr_q + 48'({cfg.row_stride_pixels, 2'b00});
			rd_ptr_q <= rd_ptr_q + AW'(1);
			yrow_q   <= yrow_q + 14'd1;
			r_q      <= r_q + 6'd1;
		end
		if (s1_move) begin
			out_q.write_address <= addr_s1;
			out_q.pixel_on_bits <= rdata_s1;
			out_q.column_enable <= en_s1;
			out_q.fg_color      <= fg_s1;
			out_q.bg_color      <= bg_s1;
			out_q.last          <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- hw/rtl/gtcr_ctrl.sv -----
module gtcr_ctrl
	import gtcr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  dp_sts_t sts,
	output logic    in_stall,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_EMIT,
		ST_ADVX,
		ST_LINECHK,
		ST_NEWLN,
		ST_TOPCHK
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && sts.kind == KIND_PRINT) begin
						state_q <= ST_MUL;
					end else if (in_valid && sts.kind == KIND_NEWLINE) begin
						state_q <= ST_NEWLN;
					end
				end
				ST_MUL:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= sts.emit_ok ? ST_EMIT : ST_ADVX;
				ST_EMIT: begin
					if (sts.can_issue && sts.last_row) begin
						state_q <= ST_ADVX;
					end
				end
				ST_ADVX:    state_q <= ST_LINECHK;
				ST_LINECHK: state_q <= sts.line_wrap ? ST_NEWLN : ST_IDLE;
				ST_NEWLN:   state_q <= ST_TOPCHK;
				ST_TOPCHK:  state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		cmd.accept     = in_valid && (state_q == ST_IDLE);
		cmd.setup_mul  = (state_q == ST_MUL);
		cmd.setup_addr = (state_q == ST_ADDR);
		cmd.issue      = (state_q == ST_EMIT) && sts.can_issue;
		cmd.adv_x      = (state_q == ST_ADVX);
		cmd.new_line   = (state_q == ST_NEWLN);
		cmd.top_chk    = (state_q == ST_TOPCHK);
	end

endmodule

// ----- hw/rtl/glyph_text_console_renderer_top.sv -----
// Text console renderer. Each input transfer is one command: load a glyph row into
// the on-chip glyph store, move the cursor to a character cell, or print a character.
// A printable character yields one result per glyph row with the row's byte address,
// pattern, clip mask and colors, then the cursor advances and wraps when needed. Load,
// set-cursor, carriage return and ignored codes are handled while idle; a newline goes
// through the new-line and top-check states. A printed character has as many rows as
// the cell height (glyph_height capped at MAX_GLYPH_HEIGHT), or none for a code beyond
// the glyph store: the multiply and address setup steps form the row start address with
// the y * stride multiplier, then the single glyph store read port yields one row per
// cycle while the output is not stalled. Results wait in an output register, so the
// next command is taken while the last row is still pending. Configuration writes are
// taken in every cycle and must happen only while the block is idle.
module glyph_text_console_renderer_top
	import gtcr_pkg::*;
#(
	parameter int GLYPH_COUNT      = DEF_GLYPH_COUNT,
	parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
	parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	gtcr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gtcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	gtcr_datapath #(
		.GLYPH_COUNT      (GLYPH_COUNT),
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
		.MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- hw/rtl/gtcr_checker.sv -----
`include "assert_macros.svh"

module gtcr_checker
	import gtcr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	logic print_xfer;

	assign print_xfer = in_valid && !in_stall && in_item.op == OP_PRINT &&
		in_item.char_code != CHAR_NUL && in_item.char_code != CHAR_LF &&
		in_item.char_code != CHAR_CR;

	// stalled result holds
	`GTCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

	// a printed character keeps the input side busy
	`GTCR_ASSERT_NEXT(a_print_busy, clk, arst_n, print_xfer, in_stall, "print transfer not followed by busy")

	// clip mask is a run of ones from the leftmost column
	`GTCR_ASSERT(a_mask_run, clk, arst_n, !out_valid || ((out_item.column_enable << 1) & ~out_item.column_enable) == 16'h0000, "column enable not contiguous")

endmodule

bind glyph_text_console_renderer_top gtcr_checker u_chk (.*);
